### rtl/sha256_stream_hasher_core_defines.svh
// Assertion macros for the SHA-256 stream hasher.
// Included by the top level only; no other dependencies.
`ifndef SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`define SHA256_STREAM_HASHER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

### rtl/sha256_pkg.sv
// Package for the SHA-256 stream hasher: state encoding, round constants and
// the round helper functions. No dependencies.
package sha256_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAD,
        ST_SCHED_RD,
        ST_SCHED_W,
        ST_ROUND_RD,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

### rtl/sha256_stream_hasher_core.sv
// SHA-256 stream hasher: one message byte per transaction, digest out as eight words.
// A byte that does not complete a block leaves the core idle and ready for the next byte.
// A completing byte stalls the input through the schedule pass (words 16..63), the 64 rounds
// and the add. The closing item adds the padding bytes and one or two such block passes, then
// eight digest transactions. aresetn (synchronous, active low) clears counters; the initial
// hash then loads word by word, with s_tready held low until it is done.
`include "sha256_stream_hasher_core_defines.svh"
module sha256_stream_hasher_core
    import sha256_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);
    state_t state_reg, state_next;

    logic [31:0] hash_reg [8];
    logic [31:0] wv_reg [8];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg, len_latch_reg;
    logic [6:0]  cnt_reg;
    logic        pad_reg;
    logic [1:0]  pad_phase_reg;
    logic [31:0] acc_reg;
    logic [31:0] w2_reg, w7_reg, w15_reg;
    logic [1:0]  rd_ph_reg;
    logic [3:0]  hinit_reg;

    // Schedule memory: 64 words, entries 0..15 are the block buffer.
    logic        sch_we;
    logic [5:0]  sch_wa, sch_ra;
    logic [31:0] sch_wd, sch_rd;

    sha256_ram #(.WIDTH(32), .DEPTH(64)) u_sched (
        .aclk (aclk), .we(sch_we), .waddr(sch_wa), .wdata(sch_wd),
        .raddr(sch_ra), .rdata(sch_rd)
    );

    logic       take;
    logic [7:0] put_b;
    logic       put_en;
    logic [31:0] put_word;
    logic [7:0] len_byte;
    logic [31:0] t1, t2, sch_new;

    assign take = s_tvalid && s_tready;

    always_comb begin
        len_byte = len_latch_reg[63 - 8 * (fill_reg[2:0]) -: 8];
        if (pad_phase_reg == 2'd0) begin
            put_b = PAD_BYTE;
        end else if (pad_phase_reg == 2'd1) begin
            put_b = 8'h00;
        end else begin
            put_b = len_byte;
        end
        if (state_reg == ST_IDLE) begin
            put_b = s_tdata;
        end
    end

    assign put_en = (state_reg == ST_IDLE && take && s_tuser) || (state_reg == ST_PAD);
    // Bytes are accumulated in acc_reg; the partly filled word is written on every byte.
    assign put_word = (fill_reg[1:0] == 2'd0) ? {put_b, 24'h0}
                    : (acc_reg | ({24'h0, put_b} << (24 - 8 * fill_reg[1:0])));

    assign t1 = wv_reg[7] + bsig1(wv_reg[4])
              + ((wv_reg[4] & wv_reg[5]) ^ (~wv_reg[4] & wv_reg[6]))
              + ROUND_K[cnt_reg[5:0]] + sch_rd;
    assign t2 = bsig0(wv_reg[0])
              + ((wv_reg[0] & wv_reg[1]) ^ (wv_reg[0] & wv_reg[2])
                 ^ (wv_reg[1] & wv_reg[2]));
    assign sch_new = sig1(w2_reg) + w7_reg + sig0(w15_reg) + sch_rd;

    always_comb begin
        sch_we = 1'b0;
        sch_wa = fill_reg[5:2];
        sch_wd = put_word;
        sch_ra = cnt_reg[5:0];
        if (put_en) begin
            sch_we = 1'b1;
        end
        if (state_reg == ST_SCHED_RD) begin
            case (rd_ph_reg)
                2'd0:    sch_ra = cnt_reg[5:0] - 6'd2;
                2'd1:    sch_ra = cnt_reg[5:0] - 6'd7;
                2'd2:    sch_ra = cnt_reg[5:0] - 6'd15;
                default: sch_ra = cnt_reg[5:0] - 6'd16;
            endcase
        end
        if (state_reg == ST_SCHED_W) begin
            sch_we = 1'b1;
            sch_wa = cnt_reg[5:0];
            sch_wd = sch_new;
        end
    end

    // Next-state logic.
    logic block_full;
    assign block_full = put_en && (fill_reg == 6'd63);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (hinit_reg != 4'd0) begin
                    state_next = ST_IDLE;
                end else if (block_full) begin
                    state_next = ST_SCHED_RD;
                end else if (take && s_tlast) begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (block_full) begin
                    state_next = ST_SCHED_RD;
                end
            end
            ST_SCHED_RD: begin
                if (cnt_reg == 7'd64) begin
                    state_next = ST_ROUND_RD;
                end else if (rd_ph_reg == 2'd3) begin
                    state_next = ST_SCHED_W;
                end
            end
            ST_SCHED_W:  state_next = ST_SCHED_RD;
            ST_ROUND_RD: state_next = ST_ROUND;
            ST_ROUND: begin
                state_next = (cnt_reg == 7'd63) ? ST_ADD : ST_ROUND_RD;
            end
            ST_ADD: begin
                if (pad_reg && pad_phase_reg == 2'd3) begin
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready && cnt_reg == 7'd7) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output logic.
    always_comb begin
        s_tready = (state_reg == ST_IDLE) && (hinit_reg == 4'd0);
        m_tvalid = (state_reg == ST_OUT);
        m_tdata  = {5'd0, cnt_reg[2:0], hash_reg[cnt_reg[2:0]]};
        m_tlast  = (cnt_reg == 7'd7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            cnt_reg       <= '0;
            pad_reg       <= 1'b0;
            pad_phase_reg <= 2'd0;
            rd_ph_reg     <= 2'd0;
            hinit_reg     <= 4'd8;
        end else begin
            state_reg <= state_next;
            if (hinit_reg != 4'd0) begin
                hash_reg[hinit_reg[2:0] - 3'd1] <= INIT_H[hinit_reg[2:0] - 3'd1];
                hinit_reg <= hinit_reg - 4'd1;
            end
            if (put_en) begin
                acc_reg  <= put_word;
                fill_reg <= fill_reg + 6'd1;
            end
            if (state_reg == ST_IDLE && take) begin
                if (s_tuser) begin
                    len_reg <= len_reg + 64'd8;
                end
                if (s_tlast) begin
                    pad_reg       <= 1'b1;
                    pad_phase_reg <= 2'd0;
                    len_latch_reg <= len_reg + (s_tuser ? 64'd8 : 64'd0);
                end
            end
            if (state_reg == ST_PAD) begin
                // Phases: marker byte, zeros, then eight length bytes, then done.
                if (pad_phase_reg == 2'd0) begin
                    pad_phase_reg <= (fill_reg + 6'd1 == LEN_POS) ? 2'd2 : 2'd1;
                end else if (pad_phase_reg == 2'd1) begin
                    if (fill_reg + 6'd1 == LEN_POS) begin
                        pad_phase_reg <= 2'd2;
                    end
                end else if (fill_reg == 6'd63) begin
                    pad_phase_reg <= 2'd3;
                end
            end
            if (block_full) begin
                cnt_reg   <= 7'd16;
                rd_ph_reg <= 2'd0;
                for (int i = 0; i < 8; i++) begin
                    wv_reg[i] <= hash_reg[i];
                end
            end
            if (state_reg == ST_SCHED_RD && cnt_reg != 7'd64) begin
                rd_ph_reg <= rd_ph_reg + 2'd1;
                case (rd_ph_reg)
                    2'd1:    w2_reg  <= sch_rd;
                    2'd2:    w7_reg  <= sch_rd;
                    2'd3:    w15_reg <= sch_rd;
                    default: ;
                endcase
            end
            if (state_reg == ST_SCHED_RD && cnt_reg == 7'd64) begin
                cnt_reg <= '0;
            end
            if (state_reg == ST_SCHED_W) begin
                cnt_reg   <= cnt_reg + 7'd1;
                rd_ph_reg <= 2'd0;
            end
            if (state_reg == ST_ROUND) begin
                wv_reg[7] <= wv_reg[6];
                wv_reg[6] <= wv_reg[5];
                wv_reg[5] <= wv_reg[4];
                wv_reg[4] <= wv_reg[3] + t1;
                wv_reg[3] <= wv_reg[2];
                wv_reg[2] <= wv_reg[1];
                wv_reg[1] <= wv_reg[0];
                wv_reg[0] <= t1 + t2;
                cnt_reg   <= cnt_reg + 7'd1;
            end
            if (state_reg == ST_ADD) begin
                for (int i = 0; i < 8; i++) begin
                    hash_reg[i] <= hash_reg[i] + wv_reg[i];
                end
                cnt_reg <= '0;
            end
            if (state_reg == ST_OUT && m_tready) begin
                if (cnt_reg == 7'd7) begin
                    cnt_reg   <= '0;
                    len_reg   <= '0;
                    fill_reg  <= '0;
                    pad_reg   <= 1'b0;
                    hinit_reg <= 4'd8;
                end else begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    // The rounds only begin once the whole schedule has been written.
    `SHA_ASSERT_IMPL(a_round_cnt, aclk, aresetn, state_reg == ST_ROUND, cnt_reg < 7'd64)
    `SHA_ASSERT_IMPL(a_no_in_busy, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    `SHA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
endmodule

### rtl/sha256_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sha256_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
